// File: rtl/core/tea_pkg.sv
// Shared types, constants and round helpers for the TEA cipher core.
`timescale 1ns / 1ps

package tea_pkg;

  localparam int          TEA_ROUNDS = 32;
  localparam int          KEY_WORDS  = 4;
  localparam int          CFG_IDX_W  = $clog2(KEY_WORDS);
  localparam logic [31:0] TEA_DELTA  = 32'h9E37_79B9;
  localparam int          SHL_AMT    = 4;
  localparam int          SHR_AMT    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = CFG_IDX_W'(3);

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] in_left;
    logic [31:0] in_right;
  } tea_in_t;

  typedef struct packed {
    logic [31:0] out_left;
    logic [31:0] out_right;
    logic        key_error;
  } tea_out_t;

  typedef struct packed {
    logic        op;
    logic        bad;
    logic [31:0] left;
    logic [31:0] right;
  } tea_stage_t;

  // running sum after n additions of the constant, modulo 2^32
  function automatic logic [31:0] round_sum(input int n);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(n);
    return prod[31:0];
  endfunction

  function automatic logic [31:0] mix_half(input logic [31:0] v, input logic [31:0] sum,
                                           input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = (v << SHL_AMT) + ka;
    b = v + sum;
    c = (v >> SHR_AMT) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

// File: rtl/core/tea_block_cipher_core.sv
// Top level of the TEA cipher core: key registers and the half-round pipeline.
`timescale 1ns / 1ps

// TEA block cipher, one 64-bit block per word.
// Key: four 32-bit registers written through cfg_we / cfg_index / cfg_wdata,
// all zero after reset. Write them only while no word is in flight.
// Input channel in_valid / in_ready / in_word: op (0 encrypt, 1 decrypt) and
// the two halves. Output channel out_valid / out_ready / out_word: the two
// halves and key_error. With an all-zero key the halves pass through unchanged
// and key_error is set.
// Each half-round has a register stage of its own, after an input register,
// so out_valid rises once a word has passed through all of them.
// A word is accepted every cycle while the output is taken.
// If out_valid is high and out_ready low, the whole pipeline holds and
// in_ready drops in the same cycle; empty stages ahead of the output still
// let words in while the output register is free.
// Reset (rst_n low, synchronous) clears all valid bits and the key.
module tea_block_cipher_core #(
  parameter int ROUNDS = tea_pkg::TEA_ROUNDS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tea_pkg::tea_in_t               in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tea_pkg::tea_out_t              out_word,
  input  logic                           cfg_we,
  input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import tea_pkg::*;

  localparam int NSTG = 2 * ROUNDS;

  logic [31:0] key0_r, key1_r, key2_r, key3_r;
  logic [NSTG:0] vld_r;
  tea_stage_t    stg_r [NSTG+1];
  tea_stage_t    stg_nxt [NSTG+1];
  logic          adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0: key0_r <= cfg_wdata;
        REG_KEY1: key1_r <= cfg_wdata;
        REG_KEY2: key2_r <= cfg_wdata;
        REG_KEY3: key3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv      = !vld_r[NSTG] || out_ready;
  assign in_ready = adv;

  always_comb begin
    stg_nxt[0].op    = in_word.op;
    stg_nxt[0].bad   = (key0_r | key1_r | key2_r | key3_r) == 32'd0;
    stg_nxt[0].left  = in_word.in_left;
    stg_nxt[0].right = in_word.in_right;
  end

  // stage k+1 applies half-round k; decryption walks the rounds backward
  for (genvar k = 0; k < NSTG; k++) begin : g_half
    localparam int          RND   = k / 2;
    localparam logic        SECND = (k % 2) == 1;
    localparam logic [31:0] SUM_E = round_sum(RND + 1);
    localparam logic [31:0] SUM_D = round_sum(ROUNDS - RND);

    logic        from_left;
    logic [31:0] src, sum, ka, kb, mix;

    always_comb begin
      from_left = stg_r[k].op ^ SECND;
      src       = from_left ? stg_r[k].left : stg_r[k].right;
      sum       = (stg_r[k].op == OP_DECRYPT) ? SUM_D : SUM_E;
      ka        = from_left ? key2_r : key0_r;
      kb        = from_left ? key3_r : key1_r;
      mix       = mix_half(src, sum, ka, kb);
      stg_nxt[k+1] = stg_r[k];
      if (!stg_r[k].bad) begin
        if (from_left) begin
          stg_nxt[k+1].right = (stg_r[k].op == OP_DECRYPT) ?
                               stg_r[k].right - mix : stg_r[k].right + mix;
        end else begin
          stg_nxt[k+1].left = (stg_r[k].op == OP_DECRYPT) ?
                              stg_r[k].left - mix : stg_r[k].left + mix;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= NSTG; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign out_valid          = vld_r[NSTG];
  assign out_word.out_left  = stg_r[NSTG].left;
  assign out_word.out_right = stg_r[NSTG].right;
  assign out_word.key_error = stg_r[NSTG].bad;

endmodule

// File: rtl/core/tea_core_chk.sv
// Port-level checker for the TEA cipher core, bound to the top level.
`timescale 1ns / 1ps

module tea_core_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input tea_pkg::tea_in_t              in_word,
  input logic                          out_valid,
  input logic                          out_ready,
  input tea_pkg::tea_out_t             out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with output register empty");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline held");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !$isunknown(in_word))
    else $error("unknown input word accepted");

endmodule

bind tea_block_cipher_core tea_core_chk u_tea_core_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

// File: sim/tea_block_cipher_checker.sv
// Checker for the TEA cipher core: tracks the key, predicts each block and compares results.
`timescale 1ns / 1ps

module tea_block_cipher_checker #(
  parameter int ROUNDS = tea_pkg::TEA_ROUNDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  tea_pkg::tea_in_t              in_word,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  tea_pkg::tea_out_t             out_word,
  input  logic                          cfg_we,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  output int unsigned                   n_pending,
  output int unsigned                   n_fail
);
  import tea_pkg::*;

  logic [3:0][31:0] key_words;
  tea_out_t         expected_blocks[$];

  function automatic tea_out_t tea_cipher_block(tea_in_t w, logic [3:0][31:0] k);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] s;
    tea_out_t    r;
    y = w.in_left;
    z = w.in_right;
    r.key_error = (k == '0);
    if (!r.key_error) begin
      if (w.op == OP_ENCRYPT) begin
        s = '0;
        for (int i = 0; i < ROUNDS; i++) begin
          s += TEA_DELTA;
          y += ((z << SHL_AMT) + k[0]) ^ (z + s) ^ ((z >> SHR_AMT) + k[1]);
          z += ((y << SHL_AMT) + k[2]) ^ (y + s) ^ ((y >> SHR_AMT) + k[3]);
        end
      end else begin
        s = 32'(64'(TEA_DELTA) * 64'(ROUNDS));
        for (int i = 0; i < ROUNDS; i++) begin
          z -= ((y << SHL_AMT) + k[2]) ^ (y + s) ^ ((y >> SHR_AMT) + k[3]);
          y -= ((z << SHL_AMT) + k[0]) ^ (z + s) ^ ((z >> SHR_AMT) + k[1]);
          s -= TEA_DELTA;
        end
      end
    end
    r.out_left  = y;
    r.out_right = z;
    return r;
  endfunction

  always @(posedge clk) begin
    tea_out_t want;
    tea_out_t pred;
    if (!rst_n) begin
      key_words = '0;
      expected_blocks.delete();
      n_fail = 0;
    end else begin
      if (in_valid && in_ready) begin
        pred = tea_cipher_block(in_word, key_words);
        expected_blocks.insert(expected_blocks.size(), pred);
      end
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $error("result word with none expected: %h", out_word);
          n_fail++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_word.out_left !== want.out_left) begin
            $error("out_left: expected %h, got %h", want.out_left, out_word.out_left);
            n_fail++;
          end
          if (out_word.out_right !== want.out_right) begin
            $error("out_right: expected %h, got %h", want.out_right, out_word.out_right);
            n_fail++;
          end
          if (out_word.key_error !== want.key_error) begin
            $error("key_error: expected %b, got %b", want.key_error, out_word.key_error);
            n_fail++;
          end
        end
      end
      if (cfg_we) begin
        key_words[cfg_index] = cfg_wdata;
      end
    end
    n_pending = expected_blocks.size();
  end

endmodule

// File: sim/tea_block_cipher_core_tb.sv
// Testbench top for the TEA cipher core: clock, reset, key loads, block stimulus and verdict.
`timescale 1ns / 1ps

module tea_block_cipher_core_tb;
  import tea_pkg::*;

  localparam int ROUNDS      = TEA_ROUNDS;
  localparam int LATENCY     = 2 * ROUNDS + 1;
  localparam int IDLE_LIMIT  = 4000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 130;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  tea_in_t              in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  tea_out_t             out_word;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY0;
  logic [31:0]          cfg_wdata = '0;
  int unsigned          n_pending;
  int unsigned          n_fail;
  int unsigned          idle_cycles = 0;
  bit                   steady = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tea_block_cipher_core #(.ROUNDS(ROUNDS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tea_block_cipher_checker #(.ROUNDS(ROUNDS)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .n_pending (n_pending),
    .n_fail    (n_fail)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_half();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [3:0][31:0] pick_key();
    logic [3:0][31:0] k;
    int               r;
    r = $urandom_range(9);
    k = {$urandom(), $urandom(), $urandom(), $urandom()};
    if (r == 0) begin
      k = '0;
    end else if (r == 1) begin
      k = '1;
    end else if (r == 2) begin
      k = '0;
      k[$urandom_range(3)] = $urandom() | 32'h1;
    end
    return k;
  endfunction

  task automatic send_block(input logic op, input logic [31:0] left, input logic [31:0] right);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{op: op, in_left: left, in_right: right};
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until every block in flight has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
    @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [3:0][31:0] k);
    cfg_put(REG_KEY0, k[0]);
    cfg_put(REG_KEY1, k[1]);
    cfg_put(REG_KEY2, k[2]);
    cfg_put(REG_KEY3, k[3]);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tea_block_cipher_core: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int gap;
    int run;
    wait (rst_n);
    forever begin
      out_ready <= 1'b1;
      run = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(8, 1);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // key still zero after reset: pass-through with key_error
    send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(OP_ENCRYPT, 32'hDEAD_BEEF, 32'h0123_4567);
    send_block(OP_DECRYPT, 32'h8000_0000, 32'h0000_0001);
    drain();

    // a single nonzero key word is enough to run the rounds
    load_key({32'h0000_0001, 32'h0, 32'h0, 32'h0});
    send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    drain();
    load_key({32'h0, 32'h0, 32'h0, 32'h8000_0000});
    send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_block(OP_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
    drain();

    load_key('1);
    send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
    drain();

    load_key({32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210});
    send_block(OP_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
    send_block(OP_DECRYPT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_block(OP_ENCRYPT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      load_key(pick_key());
      steady = ($urandom_range(3) == 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_block(logic'($urandom_range(1)), pick_half(), pick_half());
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (n_fail == 0) begin
      $display("tea_block_cipher_core: match");
    end else begin
      $display("tea_block_cipher_core: mismatch");
    end
    $finish;
  end

endmodule

// File: tea_block_cipher_core.f
rtl/core/tea_pkg.sv
rtl/core/tea_block_cipher_core.sv
rtl/core/tea_core_chk.sv
sim/tea_block_cipher_checker.sv
sim/tea_block_cipher_core_tb.sv
